// File: src/bid_pkg.sv
package bid_pkg;

   // Field widths of the request and response channels.
   localparam int OP_W        = 3;
   localparam int POS_W       = 7;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH_BACK = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_GET       = 3'd3;
   localparam logic [OP_W-1:0] OP_SET       = 3'd4;
   localparam logic [OP_W-1:0] OP_INSERT    = 3'd5;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_DONE,
      ST_SHIFT,
      ST_INSERT_WRITE
   } state_type;

   // Logical index whose slot the memory read port addresses.
   typedef enum logic [1:0] {
      RD_COUNT_M1,
      RD_FRONT,
      RD_POS,
      RD_SRC_M1
   } rd_sel_type;

   // Logical index whose slot the memory write port addresses.
   typedef enum logic [1:0] {
      WR_COUNT,
      WR_POS,
      WR_SRC_P1
   } wr_sel_type;

   typedef enum logic [1:0] {
      WORD_ZERO,
      WORD_REQ,
      WORD_RAM
   } word_sel_type;

   typedef struct packed {
      logic                 req_load;
      logic                 rd_en;
      rd_sel_type           rd_sel;
      logic                 wr_en;
      wr_sel_type           wr_sel;
      logic                 wr_from_ram;
      logic                 count_inc;
      logic                 count_dec;
      logic                 front_inc;
      logic                 src_load;
      logic                 src_dec;
      logic                 rsp_load;
      word_sel_type         rsp_word_sel;
      logic [STATUS_W-1:0]  rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            pos_lt_count;
      logic            pos_le_count;
      logic            src_gt_pos;
      logic            out_free;
   } dp_status_type;

endpackage

// File: src/bid_ram.sv
module bid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: src/bid_ctrl.sv
module bid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  bid_pkg::dp_status_type dp_status,
   output logic                   req_stall,
   output bid_pkg::ctrl_cmd_type  cmd
);
   import bid_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_stall        = (state_ff != ST_IDLE);
      cmd.req_load     = 1'b0;
      cmd.rd_en        = 1'b0;
      cmd.rd_sel       = RD_POS;
      cmd.wr_en        = 1'b0;
      cmd.wr_sel       = WR_POS;
      cmd.wr_from_ram  = 1'b0;
      cmd.count_inc    = 1'b0;
      cmd.count_dec    = 1'b0;
      cmd.front_inc    = 1'b0;
      cmd.src_load     = 1'b0;
      cmd.src_dec      = 1'b0;
      cmd.rsp_load     = 1'b0;
      cmd.rsp_word_sel = WORD_ZERO;
      cmd.rsp_status   = STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_EXEC;
            end
         end

         // Nothing is done until the response register can take a result, so a
         // write or a count update never happens twice.
         ST_EXEC: begin
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
               case (dp_status.op)
                  OP_PUSH_BACK: begin
                     cmd.rsp_load = 1'b1;
                     if (dp_status.full) begin
                        cmd.rsp_status = STATUS_FULL;
                     end else begin
                        cmd.wr_en        = 1'b1;
                        cmd.wr_sel       = WR_COUNT;
                        cmd.count_inc    = 1'b1;
                        cmd.rsp_word_sel = WORD_REQ;
                     end
                  end
                  OP_POP_BACK: begin
                     if (dp_status.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel    = RD_COUNT_M1;
                        cmd.count_dec = 1'b1;
                        state_in      = ST_READ_DONE;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (dp_status.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel    = RD_FRONT;
                        cmd.count_dec = 1'b1;
                        cmd.front_inc = 1'b1;
                        state_in      = ST_READ_DONE;
                     end
                  end
                  OP_GET: begin
                     if (!dp_status.pos_lt_count) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_RANGE;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_POS;
                        state_in   = ST_READ_DONE;
                     end
                  end
                  OP_SET: begin
                     cmd.rsp_load = 1'b1;
                     if (!dp_status.pos_lt_count) begin
                        cmd.rsp_status = STATUS_RANGE;
                     end else begin
                        cmd.wr_en        = 1'b1;
                        cmd.wr_sel       = WR_POS;
                        cmd.rsp_word_sel = WORD_REQ;
                     end
                  end
                  OP_INSERT: begin
                     if (!dp_status.pos_le_count) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_RANGE;
                     end else if (dp_status.full) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_FULL;
                     end else if (dp_status.pos_lt_count) begin
                        // Start moving the last element one place back.
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = RD_COUNT_M1;
                        cmd.src_load = 1'b1;
                        state_in     = ST_SHIFT;
                     end else begin
                        cmd.wr_en        = 1'b1;
                        cmd.wr_sel       = WR_POS;
                        cmd.count_inc    = 1'b1;
                        cmd.rsp_load     = 1'b1;
                        cmd.rsp_word_sel = WORD_REQ;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end

         ST_READ_DONE: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_word_sel = WORD_RAM;
            state_in         = ST_IDLE;
         end

         // Each cycle writes the element read in the previous cycle one slot
         // further back and, while src lies above the position, reads the next one toward the front.
         ST_SHIFT: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = WR_SRC_P1;
            cmd.wr_from_ram = 1'b1;
            if (dp_status.src_gt_pos) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_SRC_M1;
               cmd.src_dec = 1'b1;
            end else begin
               state_in = ST_INSERT_WRITE;
            end
         end

         ST_INSERT_WRITE: begin
            cmd.wr_en        = 1'b1;
            cmd.wr_sel       = WR_POS;
            cmd.count_inc    = 1'b1;
            cmd.rsp_load     = 1'b1;
            cmd.rsp_word_sel = WORD_REQ;
            state_in         = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/bid_datapath.sv
module bid_datapath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bid_pkg::ctrl_cmd_type              cmd,
   output bid_pkg::dp_status_type             dp_status,
   input  logic [bid_pkg::OP_W-1:0]           req_operation,
   input  logic [bid_pkg::POS_W-1:0]          req_position,
   input  logic [bid_pkg::WORD_W-1:0]         req_word_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bid_pkg::WORD_W-1:0]         rsp_word_out,
   output logic [bid_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bid_pkg::COUNT_OUT_W-1:0]    rsp_count_out
);
   import bid_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

   // Store slot of a logical index: front plus index, wrapped once.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                             input logic [CW-1:0] index);
      logic [CW:0] sum;
      sum = (CW+1)'(front) + (CW+1)'(index);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return AW'(sum);
   endfunction

   logic [OP_W-1:0]        req_op_ff;
   logic [POS_W-1:0]       req_pos_ff;
   logic [DATA_WIDTH-1:0]  req_word_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [AW-1:0]          front_ff;
   logic [AW-1:0]          front_in;
   logic [CW-1:0]          src_ff;
   logic                   rsp_valid_ff;
   logic [WORD_W-1:0]      rsp_word_ff;
   logic [WORD_W-1:0]      rsp_word_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   logic [CW-1:0]          pos_idx;
   logic [CMP_W-1:0]       pos_cmp;
   logic [CMP_W-1:0]       count_cmp;
   logic [CMP_W-1:0]       src_cmp;
   logic [CW-1:0]          rd_index;
   logic [CW-1:0]          wr_index;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic [DATA_WIDTH-1:0]  rd_data;

   // Request registers.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_op_ff   <= req_operation;
         req_pos_ff  <= req_position;
         req_word_ff <= DATA_WIDTH'(req_word_in);
      end
   end

   assign pos_idx   = CW'(req_pos_ff);
   assign pos_cmp   = CMP_W'(req_pos_ff);
   assign count_cmp = CMP_W'(count_ff);
   assign src_cmp   = CMP_W'(src_ff);

   always_comb begin
      dp_status.op           = req_op_ff;
      dp_status.empty        = (count_ff == '0);
      dp_status.full         = (count_ff == CW'(DEPTH));
      dp_status.pos_lt_count = (pos_cmp < count_cmp);
      dp_status.pos_le_count = (pos_cmp <= count_cmp);
      dp_status.src_gt_pos   = (src_cmp > pos_cmp);
      dp_status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_COUNT_M1: rd_index = count_ff - CW'(1);
         RD_FRONT:    rd_index = '0;
         RD_POS:      rd_index = pos_idx;
         RD_SRC_M1:   rd_index = src_ff - CW'(1);
         default:     rd_index = '0;
      endcase
      case (cmd.wr_sel)
         WR_COUNT:  wr_index = count_ff;
         WR_POS:    wr_index = pos_idx;
         WR_SRC_P1: wr_index = src_ff + CW'(1);
         default:   wr_index = pos_idx;
      endcase
   end

   assign rd_addr = slot_of(front_ff, rd_index);
   assign wr_addr = slot_of(front_ff, wr_index);
   assign wr_data = cmd.wr_from_ram ? rd_data : req_word_ff;

   bid_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      front_in = front_ff;
      if (cmd.front_inc) begin
         front_in = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         front_ff <= '0;
      end else begin
         count_ff <= count_in;
         front_ff <= front_in;
      end
   end

   // Source index of the element being moved during an insert.
   always_ff @(posedge clock) begin
      if (cmd.src_load) begin
         src_ff <= count_ff - CW'(1);
      end else if (cmd.src_dec) begin
         src_ff <= src_ff - CW'(1);
      end
   end

   always_comb begin
      case (cmd.rsp_word_sel)
         WORD_ZERO: rsp_word_in = '0;
         WORD_REQ:  rsp_word_in = WORD_W'(req_word_ff);
         WORD_RAM:  rsp_word_in = WORD_W'(rd_data);
         default:   rsp_word_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_word_ff   <= rsp_word_in;
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word_out  = rsp_word_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = rsp_count_ff;

endmodule

// File: src/bounded_indexed_deque_core.sv
// Bounded double-ended queue with indexed access, kept in a circular store.
// Request channel (req_): operation, position and word_in; an item is taken
// when req_valid is high and req_stall is low. Response channel (rsp_): one
// item per request with word_out, status and the element count afterwards.
// The block handles one request at a time and takes the next request only
// after the previous result is in the response register.
// Push, set, errors, unused codes and an insert at the back load their result
// straight from the execute state; pop back, pop front and get pass through a
// further state, as they wait on the store's registered read port; any other
// insert first moves the elements from its position on one place back, the
// single write port moving one element per cycle.
// A result may wait in the response register while the next request is
// accepted; that request completes once the response is taken. While the
// receiver stalls, the response holds unchanged.
// Reset empties the list (count and front zero) and clears rsp_valid; the
// store itself is not cleared, as only slots of live elements are ever read.
module bounded_indexed_deque_core #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bid_pkg::OP_W-1:0]        req_operation,
   input  logic [bid_pkg::POS_W-1:0]       req_position,
   input  logic [bid_pkg::WORD_W-1:0]      req_word_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bid_pkg::WORD_W-1:0]      rsp_word_out,
   output logic [bid_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bid_pkg::COUNT_OUT_W-1:0] rsp_count_out
);
   import bid_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   bid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .dp_status (dp_status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   bid_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .dp_status     (dp_status),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_word_in   (req_word_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word_out  (rsp_word_out),
      .rsp_status    (rsp_status),
      .rsp_count_out (rsp_count_out)
   );

endmodule

// File: src/bid_checker.sv
module bid_checker #(
   parameter int DEPTH = 64
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bid_pkg::WORD_W-1:0]      rsp_word_out,
   input logic [bid_pkg::STATUS_W-1:0]    rsp_status,
   input logic [bid_pkg::COUNT_OUT_W-1:0] rsp_count_out
);
   import bid_pkg::*;

   // An accepted request stalls the request channel in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
   else $error("request accepted on consecutive cycles");

   // A stalled response keeps its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_out)
         && $stable(rsp_status) && $stable(rsp_count_out))
   else $error("stalled response changed");

   // A failed operation returns a zero word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_word_out == '0))
   else $error("nonzero word with error status");

   // Full is only reported when the list holds DEPTH elements.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_count_out == COUNT_OUT_W'(DEPTH)))
   else $error("full status with wrong count");

   // Empty is only reported when the list holds nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_count_out == '0))
   else $error("empty status with nonzero count");

endmodule

bind bounded_indexed_deque_core bid_checker #(
   .DEPTH (DEPTH)
) u_bid_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_word_out  (rsp_word_out),
   .rsp_status    (rsp_status),
   .rsp_count_out (rsp_count_out)
);

// File: tb/sv/bounded_indexed_deque_checker.sv
module bounded_indexed_deque_checker #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [bid_pkg::OP_W-1:0]        req_operation,
   input  logic [bid_pkg::POS_W-1:0]       req_position,
   input  logic [bid_pkg::WORD_W-1:0]      req_word_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [bid_pkg::WORD_W-1:0]      rsp_word_out,
   input  logic [bid_pkg::STATUS_W-1:0]    rsp_status,
   input  logic [bid_pkg::COUNT_OUT_W-1:0] rsp_count_out,
   output int                              mismatch_count,
   output int                              outstanding,
   output logic [bid_pkg::COUNT_OUT_W-1:0] live_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bid_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0]      word;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_OUT_W-1:0] count;
   } deque_result_type;

   logic [WORD_W-1:0]        slot_word [DEPTH];
   int                       front_slot;
   int                       fill;
   deque_result_type         results_due [$];
   int                       errors = 0;

   function automatic int slot_of_index(input int idx);
      return (front_slot + idx) % DEPTH;
   endfunction

   // Applies one request to the shadow list and returns the response it must produce.
   function automatic deque_result_type apply_request(input logic [OP_W-1:0] op,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [WORD_W-1:0] word);
      deque_result_type r;
      int               i;
      r = '0;
      r.status = STATUS_OK;
      case (op)
         OP_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               slot_word[slot_of_index(fill)] = word;
               fill = fill + 1;
               r.word = word;
            end
         end
         OP_POP_BACK: begin
            if (fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.word = slot_word[slot_of_index(fill - 1)];
               fill = fill - 1;
            end
         end
         OP_POP_FRONT: begin
            if (fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.word = slot_word[slot_of_index(0)];
               front_slot = (front_slot + 1) % DEPTH;
               fill = fill - 1;
            end
         end
         OP_GET: begin
            if (int'(pos) >= fill) begin
               r.status = STATUS_RANGE;
            end else begin
               r.word = slot_word[slot_of_index(int'(pos))];
            end
         end
         OP_SET: begin
            if (int'(pos) >= fill) begin
               r.status = STATUS_RANGE;
            end else begin
               slot_word[slot_of_index(int'(pos))] = word;
               r.word = word;
            end
         end
         OP_INSERT: begin
            // The index check wins over the full check.
            if (int'(pos) > fill) begin
               r.status = STATUS_RANGE;
            end else if (fill >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = fill; i > int'(pos); i--) begin
                  slot_word[slot_of_index(i)] = slot_word[slot_of_index(i - 1)];
               end
               slot_word[slot_of_index(int'(pos))] = word;
               fill = fill + 1;
               r.word = word;
            end
         end
         default: begin
         end
      endcase
      r.count = fill[COUNT_OUT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      deque_result_type want;
      if (reset) begin
         front_slot = 0;
         fill = 0;
         results_due.delete();
      end else begin
         // A response never belongs to a request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10) begin
                  $display("%0t: response with no request pending: %s %h status %0d count %0d",
                           $realtime, "word", rsp_word_out, rsp_status,
                           rsp_count_out);
               end
            end else begin
               want = results_due.pop_front();
               if (rsp_word_out !== want.word || rsp_status !== want.status ||
                   rsp_count_out !== want.count) begin
                  errors = errors + 1;
                  if (errors <= 10) begin
                     $display("%0t: expected word %h status %0d count %0d, %s",
                              $realtime, want.word, want.status, want.count,
                              "got the following");
                     $display("   word %h status %0d count %0d",
                              rsp_word_out, rsp_status, rsp_count_out);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            results_due.push_back(apply_request(req_operation, req_position, req_word_in));
         end
      end
      mismatch_count <= errors;
      outstanding <= results_due.size();
      live_count <= fill[COUNT_OUT_W-1:0];
   end

endmodule

// File: tb/sv/bounded_indexed_deque_core_tb.sv
module bounded_indexed_deque_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bid_pkg::*;

   localparam int DEPTH         = 64;
   localparam int PHASE_COUNT   = 5;
   localparam int PHASE_ITEMS   = 320;
   localparam int QUIET_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 80;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   // Sender idle and receiver stall rates, in percent, for each random phase.
   localparam int PHASE_IDLE  [PHASE_COUNT] = '{0, 68, 0, 22, 0};
   localparam int PHASE_STALL [PHASE_COUNT] = '{0, 0, 68, 22, 0};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_operation = '0;
   logic [POS_W-1:0]       req_position = '0;
   logic [WORD_W-1:0]      req_word_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WORD_W-1:0]      rsp_word_out;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_count_out;

   int                     mismatches;
   int                     pending;
   logic [COUNT_OUT_W-1:0] live_count;
   int                     idle_pct = 0;
   int                     stall_pct = 0;
   int                     quiet_cycles = 0;
   bit                     growing = 1'b1;

   always #2 clock = ~clock;

   bounded_indexed_deque_core #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(WORD_W)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word_out (rsp_word_out),
      .rsp_status   (rsp_status),
      .rsp_count_out(rsp_count_out)
   );

   bounded_indexed_deque_checker #(
      .DEPTH(DEPTH)
   ) deque_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_word_in   (req_word_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word_out  (rsp_word_out),
      .rsp_status    (rsp_status),
      .rsp_count_out (rsp_count_out),
      .mismatch_count(mismatches),
      .outstanding   (pending),
      .live_count    (live_count)
   );

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // The run is declared hung once no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [WORD_W-1:0] word);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_position <= pos;
      req_word_in <= word;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Runs of growth until full and of shrinking until empty, with some noise mixed in.
   task automatic random_item();
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] word;
      int                roll;
      int                cnt;
      cnt = int'(live_count);
      if (growing && cnt >= DEPTH && $urandom_range(3) == 0) begin
         growing = 1'b0;
      end else if (!growing && cnt == 0 && $urandom_range(3) == 0) begin
         growing = 1'b1;
      end else if ($urandom_range(99) == 0) begin
         growing = !growing;
      end
      roll = $urandom_range(99);
      if (roll < 70) begin
         if (growing) op = (roll < 45) ? OP_PUSH_BACK : OP_INSERT;
         else op = (roll < 35) ? OP_POP_BACK : OP_POP_FRONT;
      end else if (roll < 80) begin
         if (growing) op = (roll < 75) ? OP_POP_BACK : OP_POP_FRONT;
         else op = (roll < 75) ? OP_PUSH_BACK : OP_INSERT;
      end else if (roll < 89) begin
         op = OP_GET;
      end else if (roll < 97) begin
         op = OP_SET;
      end else begin
         op = roll[0] ? OP_SPARE_7 : OP_SPARE_6;
      end
      roll = $urandom_range(99);
      if (roll < 15) begin
         pos = POS_W'($urandom_range(127));
      end else if (roll < 30) begin
         pos = POS_W'(cnt);
      end else if (op == OP_INSERT || cnt == 0) begin
         pos = POS_W'($urandom_range(cnt));
      end else begin
         pos = POS_W'($urandom_range(cnt - 1));
      end
      roll = $urandom_range(99);
      if (roll < 5) word = '0;
      else if (roll < 10) word = '1;
      else word = $urandom;
      send_item(op, pos, word);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_POP_BACK, 0, 0);
      send_item(OP_POP_FRONT, 0, 0);
      send_item(OP_GET, 0, 0);
      send_item(OP_SET, 0, 32'h1111_1111);
      send_item(OP_INSERT, 1, 32'h2222_2222);
      send_item(OP_INSERT, 0, 32'hFFFF_FFFF);
      send_item(OP_PUSH_BACK, 0, 32'h0000_0000);
      send_item(OP_PUSH_BACK, 127, 32'hA5A5_5A5A);
      send_item(OP_INSERT, 3, 32'h1234_5678);
      send_item(OP_INSERT, 1, 32'hDEAD_BEEF);
      send_item(OP_INSERT, 64, 32'h3333_3333);
      send_item(OP_GET, 0, 0);
      send_item(OP_GET, 4, 0);
      send_item(OP_GET, 5, 0);
      send_item(OP_SET, 2, 32'h0F0F_F0F0);
      send_item(OP_SET, 127, 32'h4444_4444);
      send_item(OP_GET, 2, 0);
      send_item(OP_SPARE_6, 127, 32'hFFFF_FFFF);
      send_item(OP_SPARE_7, 64, 0);
      send_item(OP_POP_FRONT, 0, 0);
      send_item(OP_POP_BACK, 0, 0);
      send_item(OP_GET, 0, 0);
      wait_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         idle_pct = PHASE_IDLE[phase];
         stall_pct = PHASE_STALL[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_item();
         end
         // Hold the sender back until every response of this phase has come.
         wait_drained();
      end

      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
